FILE: hw/rtl/route_table_first_match_top_assert.svh
// Assertion macros for the route table first-match block.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef ROUTE_TABLE_FIRST_MATCH_TOP_ASSERT_SVH
`define ROUTE_TABLE_FIRST_MATCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RTFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table check failed");

// Next-cycle implication, disabled while in reset.
`define RTFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table check failed");

`endif

FILE: hw/rtl/rtfm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the route table first-match block.
// No dependencies; every other file in hw/rtl but the assertion header refers to this package.
package rtfm_pkg;

    localparam int MAX_ROUTES_DEF = 64;
    localparam int MAX_IFACES_DEF = 16;

    localparam int ACTION_W      = 2;
    localparam int INDEX_W       = 6;
    localparam int ADDR_W        = 32;
    localparam int IFACE_W       = 4;
    localparam int ROUTE_COUNT_W = 7;
    localparam int IFACE_COUNT_W = 5;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;

    localparam logic [ACTION_W-1:0] ACT_WR_ROUTE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WR_IFACE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 2'd2;

    localparam logic [1:0] REG_ROUTE_COUNT = 2'd0;
    localparam logic [1:0] REG_IFACE_COUNT = 2'd1;
    localparam logic [1:0] REG_PREF_SRC    = 2'd2;

    localparam logic [ADDR_W-1:0] NET_A_MASK = 32'hFF00_0000;
    localparam logic [ADDR_W-1:0] LOOP_NET   = 32'h7F00_0000;
    localparam logic [ADDR_W-1:0] LOOP_HOST  = 32'h7F00_0001;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  entry_index;
        logic [ADDR_W-1:0]   entry_addr;
        logic [ADDR_W-1:0]   entry_mask;
        logic [IFACE_W-1:0]  entry_iface;
        logic [ADDR_W-1:0]   lookup_addr;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [IFACE_W-1:0] out_iface;
        logic [ADDR_W-1:0]  source_addr;
        logic               via_loopback;
    } result_t;

    // Search token walking the route cells.
    typedef struct packed {
        logic               active;
        logic               hit;
        logic [IFACE_W-1:0] iface;
    } rt_tok_t;

    // Search token walking the interface cells.
    typedef struct packed {
        logic               active;
        logic               route_hit;
        logic [IFACE_W-1:0] route_iface;
        logic               local_hit;
        logic               loop_hit;
        logic [IFACE_W-1:0] loop_slot;
        logic [ADDR_W-1:0]  src;
    } if_tok_t;

    // Write beat decoded for the table cells.
    typedef struct packed {
        logic               route_en;
        logic               iface_en;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  mask;
        logic [IFACE_W-1:0] iface;
    } wr_t;

endpackage

FILE: hw/rtl/route_table_first_match_top.sv
`timescale 1ns / 1ps
// Top level of the route table first-match block: APB registers, command
// handshake and the two cell chains. Depends on rtfm_pkg and both cell modules.
//
// Usage:
//   Command channel: present an item on 'item' with 'start' high; it is taken
//   at the clock edge where start is high and busy is low. Route and interface
//   writes land in their cell at that edge, give no result and leave busy low,
//   so a write beat can follow every cycle. A lookup raises busy.
//   Lookup: a token walks MAX_ROUTES route cells (one cell per cycle, first
//   match wins), then MAX_IFACES interface cells (locality test, loopback
//   slot, source address of the chosen interface). The result appears on
//   'result' with 'done' high for exactly one cycle, registered from the token
//   leaving the last interface cell; busy drops in that same cycle, so a new
//   lookup is taken only after the previous one has given its result.
//   The lookup time is set by the length of the two cell chains.
//   The receiver cannot stall: sample the result while done is high.
//   Registers: route_count at 0x0, iface_count at 0x4, preferred_source at
//   0x8; write them only while idle. pready is tied high.
//   Reset clears registers, busy, done and all tokens in flight; table
//   entries hold garbage until written.
module route_table_first_match_top #(
    parameter int MAX_ROUTES = rtfm_pkg::MAX_ROUTES_DEF,
    parameter int MAX_IFACES = rtfm_pkg::MAX_IFACES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  rtfm_pkg::item_t                     item,
    // Result channel
    output logic                                done,
    output rtfm_pkg::result_t                   result,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtfm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rtfm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rtfm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Configuration registers
    logic [rtfm_pkg::ROUTE_COUNT_W-1:0] route_count_reg;
    logic [rtfm_pkg::IFACE_COUNT_W-1:0] iface_count_reg;
    logic [rtfm_pkg::ADDR_W-1:0]        pref_src_reg;
    logic                               cfg_wr;

    // Control and payload registers
    logic                        busy_reg,  busy_next;
    logic                        start_tok_reg, start_tok_next;
    logic                        done_reg,  done_next;
    rtfm_pkg::result_t           result_reg, result_next;
    logic [rtfm_pkg::ADDR_W-1:0] dest_reg;

    logic                        accept;
    logic                        accept_lookup;
    rtfm_pkg::wr_t               wr;

    rtfm_pkg::rt_tok_t rt_tok [0:MAX_ROUTES];
    rtfm_pkg::if_tok_t if_tok [0:MAX_IFACES];
    rtfm_pkg::if_tok_t tail;
    logic              is_local;

    // ---------------------------------------------------------------
    // APB register file: write on the access phase, read back always.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count_reg <= '0;
            iface_count_reg <= '0;
            pref_src_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rtfm_pkg::REG_ROUTE_COUNT: route_count_reg <= pwdata[rtfm_pkg::ROUTE_COUNT_W-1:0];
                rtfm_pkg::REG_IFACE_COUNT: iface_count_reg <= pwdata[rtfm_pkg::IFACE_COUNT_W-1:0];
                rtfm_pkg::REG_PREF_SRC:    pref_src_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rtfm_pkg::REG_ROUTE_COUNT: prdata = 32'(route_count_reg);
            rtfm_pkg::REG_IFACE_COUNT: prdata = 32'(iface_count_reg);
            rtfm_pkg::REG_PREF_SRC:    prdata = pref_src_reg;
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Command beat decode. Writes go straight to the cells; a lookup
    // latches its destination and launches a token into the chain.
    // ---------------------------------------------------------------
    assign accept        = start && !busy_reg;
    assign accept_lookup = accept && (item.action == rtfm_pkg::ACT_LOOKUP);

    always_comb
    begin
        wr.route_en = accept && (item.action == rtfm_pkg::ACT_WR_ROUTE);
        wr.iface_en = accept && (item.action == rtfm_pkg::ACT_WR_IFACE);
        wr.index    = item.entry_index;
        wr.addr     = item.entry_addr;
        wr.mask     = item.entry_mask;
        wr.iface    = item.entry_iface;
    end

    always_ff @(posedge clk)
    begin
        if (accept_lookup)
        begin
            dest_reg <= item.lookup_addr;
        end
    end

    // ---------------------------------------------------------------
    // Route chain: launch token, advance one cell per cycle.
    // ---------------------------------------------------------------
    always_comb
    begin
        rt_tok[0].active = start_tok_reg;
        rt_tok[0].hit    = 1'b0;
        rt_tok[0].iface  = '0;
    end

    for (genvar r = 0; r < MAX_ROUTES; r++)
    begin : g_route
        rtfm_route_cell #(
            .IDX (r)
        ) u_route_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr          (wr),
            .route_count (route_count_reg),
            .dest        (dest_reg),
            .tok_in      (rt_tok[r]),
            .tok_out     (rt_tok[r+1])
        );
    end

    // ---------------------------------------------------------------
    // Interface chain: carry the route verdict along with the local test.
    // ---------------------------------------------------------------
    always_comb
    begin
        if_tok[0].active      = rt_tok[MAX_ROUTES].active;
        if_tok[0].route_hit   = rt_tok[MAX_ROUTES].hit;
        if_tok[0].route_iface = rt_tok[MAX_ROUTES].iface;
        if_tok[0].local_hit   = 1'b0;
        if_tok[0].loop_hit    = 1'b0;
        if_tok[0].loop_slot   = '0;
        if_tok[0].src         = '0;
    end

    for (genvar f = 0; f < MAX_IFACES; f++)
    begin : g_iface
        rtfm_iface_cell #(
            .IDX (f)
        ) u_iface_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr          (wr),
            .iface_count (iface_count_reg),
            .dest        (dest_reg),
            .tok_in      (if_tok[f]),
            .tok_out     (if_tok[f+1])
        );
    end

    // ---------------------------------------------------------------
    // Final select: local destinations go via loopback, others via the
    // first matching route.
    // ---------------------------------------------------------------
    assign tail     = if_tok[MAX_IFACES];
    assign is_local = tail.local_hit
                   || (dest_reg == '0)
                   || ((dest_reg & rtfm_pkg::NET_A_MASK) == rtfm_pkg::LOOP_NET);

    always_comb
    begin
        result_next = result_reg;
        if (tail.active)
        begin
            if (is_local)
            begin
                result_next.found        = tail.loop_hit;
                result_next.out_iface    = tail.loop_hit ? tail.loop_slot : '0;
                result_next.source_addr  = rtfm_pkg::LOOP_HOST;
                result_next.via_loopback = 1'b1;
            end
            else
            begin
                result_next.found        = tail.route_hit;
                result_next.out_iface    = tail.route_hit ? tail.route_iface : '0;
                result_next.via_loopback = 1'b0;
                if (!tail.route_hit)
                begin
                    result_next.source_addr = '0;
                end
                else if (pref_src_reg != '0)
                begin
                    result_next.source_addr = pref_src_reg;
                end
                else
                begin
                    result_next.source_addr = tail.src;
                end
            end
        end
    end

    // Hold busy from lookup accept until the token leaves the last cell.
    always_comb
    begin
        start_tok_next = accept_lookup;
        done_next      = tail.active;
        busy_next      = busy_reg;
        if (accept_lookup)
        begin
            busy_next = 1'b1;
        end
        else if (tail.active)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_tok_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_tok_reg <= start_tok_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/rtfm_route_cell.sv
`timescale 1ns / 1ps
// One route table entry plus one stage of the route search chain.
// Depends on rtfm_pkg.
module rtfm_route_cell #(
    parameter int IDX = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rtfm_pkg::wr_t                          wr,
    input  logic [rtfm_pkg::ROUTE_COUNT_W-1:0]     route_count,
    input  logic [rtfm_pkg::ADDR_W-1:0]            dest,
    input  rtfm_pkg::rt_tok_t                      tok_in,
    output rtfm_pkg::rt_tok_t                      tok_out
);

    logic [rtfm_pkg::ADDR_W-1:0]  dest_reg;
    logic [rtfm_pkg::ADDR_W-1:0]  mask_reg;
    logic [rtfm_pkg::IFACE_W-1:0] iface_reg;
    rtfm_pkg::rt_tok_t            tok_reg;
    rtfm_pkg::rt_tok_t            tok_next;
    logic                         wr_hit;
    logic                         entry_valid;
    logic                         match;

    assign wr_hit      = wr.route_en && (32'(wr.index) == 32'(IDX));
    assign entry_valid = 32'(IDX) < 32'(route_count);
    assign match       = entry_valid && ((dest & mask_reg) == dest_reg);

    // First match wins: take the entry only if nothing upstream hit.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.hit && match)
        begin
            tok_next.hit   = 1'b1;
            tok_next.iface = iface_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            dest_reg  <= wr.addr;
            mask_reg  <= wr.mask;
            iface_reg <= wr.iface;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/rtfm_iface_cell.sv
`timescale 1ns / 1ps
// One interface address entry plus one stage of the interface search chain.
// Depends on rtfm_pkg.
module rtfm_iface_cell #(
    parameter int IDX = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rtfm_pkg::wr_t                          wr,
    input  logic [rtfm_pkg::IFACE_COUNT_W-1:0]     iface_count,
    input  logic [rtfm_pkg::ADDR_W-1:0]            dest,
    input  rtfm_pkg::if_tok_t                      tok_in,
    output rtfm_pkg::if_tok_t                      tok_out
);

    logic [rtfm_pkg::ADDR_W-1:0] addr_reg;
    rtfm_pkg::if_tok_t           tok_reg;
    rtfm_pkg::if_tok_t           tok_next;
    logic                        wr_hit;
    logic                        entry_valid;

    assign wr_hit      = wr.iface_en && (32'(wr.index) == 32'(IDX));
    assign entry_valid = 32'(IDX) < 32'(iface_count);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active)
        begin
            // Destination equals one of our own addresses: local.
            if (entry_valid && (addr_reg == dest))
            begin
                tok_next.local_hit = 1'b1;
            end
            // Lowest valid slot holding the loopback host.
            if (entry_valid && !tok_in.loop_hit && (addr_reg == rtfm_pkg::LOOP_HOST))
            begin
                tok_next.loop_hit  = 1'b1;
                tok_next.loop_slot = rtfm_pkg::IFACE_W'(IDX);
            end
            // Pick up the address of the interface the route leads to.
            if (32'(IDX) == 32'(tok_in.route_iface))
            begin
                tok_next.src = addr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            addr_reg <= wr.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/rtfm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the route table first-match block, bound to the top.
// Depends on rtfm_pkg and route_table_first_match_top_assert.svh.
`include "route_table_first_match_top_assert.svh"

module rtfm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input rtfm_pkg::item_t   item,
    input logic              done,
    input rtfm_pkg::result_t result
);

    // A lookup beat must raise busy.
    `RTFM_ASSERT_NEXT(a_lookup_busy, start && !busy && item.action == rtfm_pkg::ACT_LOOKUP, busy)
    // Result strobe is a single cycle and the block is free again.
    `RTFM_ASSERT_NEXT(a_done_pulse, done, !done)
    `RTFM_ASSERT_NOW(a_done_idle, done, !busy)
    // No interface chosen means slot zero.
    `RTFM_ASSERT_NOW(a_miss_slot, done && !result.found, result.out_iface == '0)
    // Local destinations always take the loopback host as source.
    `RTFM_ASSERT_NOW(a_loop_src, done && result.via_loopback, result.source_addr == rtfm_pkg::LOOP_HOST)

endmodule

bind route_table_first_match_top rtfm_checker u_rtfm_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for route_table_first_match_top: command beats in, lookup answers out,
// checked against a cycle-free copy of the route and interface tables.
// Depends on rtfm_pkg and the block RTL only.
module testbench;
    import rtfm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int NUM_ROUTES     = MAX_ROUTES_DEF;
    localparam int NUM_IFACES     = MAX_IFACES_DEF;
    // Accepting edge to result strobe, plus a little slack.
    localparam int LOOKUP_LATENCY = NUM_ROUTES + NUM_IFACES + 1;
    localparam int SETTLE_CYCLES  = LOOKUP_LATENCY + 4;
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int PHASE_ITEMS    = 72;
    // The one action code the block decodes to nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    route_table_first_match_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench copy of the block state. Tables are updated at the edge that
    // accepts a write beat; registers at the edge that completes an APB write.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]        route_dest [NUM_ROUTES];
    logic [ADDR_W-1:0]        route_mask [NUM_ROUTES];
    logic [IFACE_W-1:0]       route_port [NUM_ROUTES];
    logic [ADDR_W-1:0]        iface_addr [NUM_IFACES];
    logic [ROUTE_COUNT_W-1:0] route_limit;
    logic [IFACE_COUNT_W-1:0] iface_limit;
    logic [ADDR_W-1:0]        pref_src;

    // Answers owed by the block, oldest first.
    result_t pending_decisions[$];

    int mismatch_count   = 0;
    int lookups_checked  = 0;
    int local_answers    = 0;
    int routed_answers   = 0;
    int unrouted_answers = 0;
    int table_writes     = 0;
    int settings_used    = 0;

    // Counts saturate at the table depth when searching.
    function automatic int active_routes();
        return (int'(route_limit) < NUM_ROUTES) ? int'(route_limit) : NUM_ROUTES;
    endfunction

    function automatic int active_ifaces();
        return (int'(iface_limit) < NUM_IFACES) ? int'(iface_limit) : NUM_IFACES;
    endfunction

    // Outgoing interface and source address for one destination.
    function automatic result_t route_decision(input logic [ADDR_W-1:0] dest);
        result_t answer;
        int      iface_span;
        int      route_span;
        logic    is_local;
        answer     = '0;
        iface_span = active_ifaces();
        route_span = active_routes();
        // Local host: unspecified address, anything in 127/8, or one of our own addresses.
        is_local = (dest == '0) || ((dest & NET_A_MASK) == LOOP_NET);
        for (int i = 0; i < iface_span; i++)
            if (iface_addr[i] == dest)
                is_local = 1'b1;
        if (is_local)
        begin
            // Source is always the loopback host; the lowest loopback slot wins, if any.
            answer.via_loopback = 1'b1;
            answer.source_addr  = LOOP_HOST;
            for (int i = 0; i < iface_span && !answer.found; i++)
                if (iface_addr[i] == LOOP_HOST)
                begin
                    answer.found     = 1'b1;
                    answer.out_iface = IFACE_W'(i);
                end
        end
        else
        begin
            // First route in table order wins.
            for (int i = 0; i < route_span && !answer.found; i++)
                if ((dest & route_mask[i]) == route_dest[i])
                begin
                    answer.found     = 1'b1;
                    answer.out_iface = route_port[i];
                    if (pref_src != '0)
                        answer.source_addr = pref_src;
                    else if (int'(route_port[i]) < NUM_IFACES)
                        answer.source_addr = iface_addr[route_port[i]];
                end
        end
        return answer;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic item_t noise_item();
        item_t it;
        it.action      = ACTION_W'($urandom);
        it.entry_index = INDEX_W'($urandom);
        it.entry_addr  = ADDR_W'($urandom);
        it.entry_mask  = ADDR_W'($urandom);
        it.entry_iface = IFACE_W'($urandom);
        it.lookup_addr = ADDR_W'($urandom);
        return it;
    endfunction

    function automatic item_t table_entry(input logic [ACTION_W-1:0] act, input int slot,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] mask,
                                          input logic [IFACE_W-1:0] port);
        item_t it;
        it             = noise_item();
        it.action      = act;
        it.entry_index = INDEX_W'(slot);
        it.entry_addr  = addr;
        it.entry_mask  = mask;
        it.entry_iface = port;
        return it;
    endfunction

    function automatic item_t lookup_item(input logic [ADDR_W-1:0] dest);
        item_t it;
        it             = noise_item();
        it.action      = ACT_LOOKUP;
        it.lookup_addr = dest;
        return it;
    endfunction

    // Prefix masks, mostly /8 and longer; a few entries are left unmasked so they never hit.
    function automatic item_t random_route_entry(input int slot);
        item_t it;
        int    plen;
        it             = noise_item();
        it.action      = ACT_WR_ROUTE;
        it.entry_index = INDEX_W'(slot);
        plen           = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 32);
        it.entry_mask  = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
        if ($urandom_range(0, 9) != 0)
            it.entry_addr = it.entry_addr & it.entry_mask;
        return it;
    endfunction

    function automatic item_t random_iface_entry(input int slot);
        item_t it;
        int    pick;
        it             = noise_item();
        it.action      = ACT_WR_IFACE;
        it.entry_index = INDEX_W'(slot);
        pick           = $urandom_range(0, 15);
        if (pick < 2)
            it.entry_addr = LOOP_HOST;
        else if (pick == 2)
            it.entry_addr = LOOP_NET | (ADDR_W'($urandom) & ~NET_A_MASK);
        return it;
    endfunction

    // Mostly lookups aimed at live routes and local addresses; the rest table writes and noise.
    function automatic item_t next_random_item();
        item_t it;
        int    roll;
        int    aim;
        int    slot;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            it = random_route_entry($urandom_range(0, NUM_ROUTES - 1));
        else if (roll < 16)
            it = random_iface_entry(($urandom_range(0, 4) == 0)
                                    ? $urandom_range(NUM_IFACES, (1 << INDEX_W) - 1)
                                    : $urandom_range(0, NUM_IFACES - 1));
        else if (roll < 19)
        begin
            it        = noise_item();
            it.action = ACT_UNUSED;
        end
        else
        begin
            it  = lookup_item(ADDR_W'($urandom));
            aim = $urandom_range(0, 99);
            if (aim < 45 && active_routes() > 0)
            begin
                slot           = $urandom_range(0, active_routes() - 1);
                it.lookup_addr = route_dest[slot] | (ADDR_W'($urandom) & ~route_mask[slot]);
            end
            else if (aim < 60 && active_ifaces() > 0)
                it.lookup_addr = iface_addr[$urandom_range(0, active_ifaces() - 1)];
            else if (aim < 64)
                it.lookup_addr = '0;
            else if (aim < 72)
                it.lookup_addr = LOOP_NET | (ADDR_W'($urandom) & ~NET_A_MASK);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    // Hold the beat until an edge sees start high and busy low, then advance the bench copy.
    task automatic send_item(input item_t beat);
        @(negedge clk);
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        case (beat.action)
            ACT_WR_ROUTE:
            begin
                route_dest[beat.entry_index] = beat.entry_addr;
                route_mask[beat.entry_index] = beat.entry_mask;
                route_port[beat.entry_index] = beat.entry_iface;
                table_writes++;
            end
            ACT_WR_IFACE:
            begin
                // Slots past the interface table are dropped by the block.
                if (int'(beat.entry_index) < NUM_IFACES)
                begin
                    iface_addr[beat.entry_index] = beat.entry_addr;
                    table_writes++;
                end
            end
            ACT_LOOKUP:
                pending_decisions.push_back(route_decision(beat.lookup_addr));
            default:
                ;
        endcase
    endtask

    // Drop start for a while; keep the payload moving so nothing leaks through while idle.
    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= noise_item();
        end
    endtask

    // Stop sending until every owed answer has come, then let the pipeline empty.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: the block strobes done for one cycle and cannot be stalled,
    // so every strobe is taken at the edge that ends it.
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [ADDR_W-1:0] wanted,
                               input logic [ADDR_W-1:0] seen);
        if (seen !== wanted)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, wanted, seen);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t wanted;
        if (rst_n && done)
        begin
            if (pending_decisions.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with nothing owed, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                wanted = pending_decisions.pop_front();
                check_field("found", ADDR_W'(wanted.found), ADDR_W'(result.found));
                check_field("out_iface", ADDR_W'(wanted.out_iface), ADDR_W'(result.out_iface));
                check_field("source_addr", wanted.source_addr, result.source_addr);
                check_field("via_loopback", ADDR_W'(wanted.via_loopback),
                            ADDR_W'(result.via_loopback));
                lookups_checked++;
                if (wanted.via_loopback)
                    local_answers++;
                else if (wanted.found)
                    routed_answers++;
                else
                    unrouted_answers++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration side
    // ------------------------------------------------------------------
    // Write one register (setup, then access), then read it back the same way.
    task automatic write_register(input logic [1:0] reg_idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] held;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_idx)
            REG_ROUTE_COUNT: route_limit = value[ROUTE_COUNT_W-1:0];
            REG_IFACE_COUNT: iface_limit = value[IFACE_COUNT_W-1:0];
            REG_PREF_SRC:    pref_src    = value;
            default:         ;
        endcase
        case (reg_idx)
            REG_ROUTE_COUNT: held = CFG_DATA_W'(route_limit);
            REG_IFACE_COUNT: held = CFG_DATA_W'(iface_limit);
            default:         held = pref_src;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("register readback", held, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle; junk above the count fields must be dropped.
    task automatic apply_setting(input int routes, input int ifaces,
                                 input logic [ADDR_W-1:0] pref);
        drain_results();
        write_register(REG_ROUTE_COUNT,
                       (CFG_DATA_W'($urandom) << ROUTE_COUNT_W) | CFG_DATA_W'(routes));
        write_register(REG_IFACE_COUNT,
                       (CFG_DATA_W'($urandom) << IFACE_COUNT_W) | CFG_DATA_W'(ifaces));
        write_register(REG_PREF_SRC, pref);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Both counts are zero out of reset, so lookups read no entry yet.
    task automatic test_empty_tables();
        send_item(lookup_item('0));
        send_item(lookup_item({ADDR_W{1'b1}}));
        send_item(lookup_item(LOOP_HOST));
        send_item(table_entry(ACT_UNUSED, 0, '0, '0, '0));
        send_item(table_entry(ACT_WR_IFACE, (1 << INDEX_W) - 1, LOOP_HOST, '0, '0));
    endtask

    // Fill every slot back to back so no later lookup reads an unwritten entry.
    task automatic load_tables();
        for (int i = 0; i < NUM_ROUTES; i++)
            send_item(random_route_entry(i));
        for (int i = 0; i < NUM_IFACES; i++)
            send_item(random_iface_entry(i));
    endtask

    task automatic test_directed_lookups();
        apply_setting(NUM_ROUTES, NUM_IFACES, '0);
        // Host route at the top of the table, catch-all at the bottom.
        send_item(table_entry(ACT_WR_ROUTE, 0, {ADDR_W{1'b1}}, {ADDR_W{1'b1}}, {IFACE_W{1'b1}}));
        send_item(table_entry(ACT_WR_ROUTE, NUM_ROUTES - 1, '0, '0, '0));
        send_item(table_entry(ACT_WR_ROUTE, 1, 32'h0A00_0000, NET_A_MASK, 4'd7));
        send_item(table_entry(ACT_WR_IFACE, NUM_IFACES - 1, 32'hC0A8_0101, '0, '0));
        send_item(lookup_item({ADDR_W{1'b1}}));
        send_item(lookup_item(32'h0A12_3456));
        // Two loopback slots: the lower one must be reported.
        send_item(table_entry(ACT_WR_IFACE, 0, LOOP_HOST, '0, '0));
        send_item(table_entry(ACT_WR_IFACE, 9, LOOP_HOST, '0, '0));
        send_item(lookup_item('0));
        send_item(lookup_item(LOOP_NET));
        send_item(lookup_item(LOOP_NET | ~NET_A_MASK));
        send_item(lookup_item(LOOP_HOST));
        // Own address counts as local even outside 127/8.
        send_item(lookup_item(32'hC0A8_0101));
        send_item(table_entry(ACT_WR_IFACE, 0, 32'h0A00_0002, '0, '0));
        send_item(lookup_item(LOOP_HOST));
        // Writes past the interface table and the unused code must leave no trace.
        send_item(table_entry(ACT_WR_IFACE, NUM_IFACES, LOOP_HOST, '0, '0));
        send_item(table_entry(ACT_WR_IFACE, (1 << INDEX_W) - 1, '0, '0, '0));
        send_item(table_entry(ACT_UNUSED, 5, LOOP_HOST, '0, '0));
        send_item(lookup_item(32'h0A00_0002));
    endtask

    task automatic test_register_extremes();
        // Forced source overrides the interface address on routed answers only.
        apply_setting(NUM_ROUTES, NUM_IFACES, {ADDR_W{1'b1}});
        send_item(lookup_item(32'h0A12_3456));
        send_item(lookup_item(LOOP_HOST));
        // Counts past the table size saturate.
        apply_setting((1 << ROUTE_COUNT_W) - 1, (1 << IFACE_COUNT_W) - 1, '0);
        send_item(lookup_item(ADDR_W'($urandom)));
        send_item(lookup_item(LOOP_NET | 32'h0012_3456));
        // Nothing valid: local with no loopback slot, and no route at all.
        apply_setting(0, 0, '0);
        send_item(lookup_item(LOOP_HOST));
        send_item(lookup_item(32'h0A12_3456));
    endtask

    // Bursts of random length with random gaps; a gap can land anywhere in a lookup.
    task automatic test_random_traffic();
        item_t beat;
        int    sent;
        int    burst;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_setting(NUM_ROUTES, NUM_IFACES, '0);
                1: apply_setting((1 << ROUTE_COUNT_W) - 1, (1 << IFACE_COUNT_W) - 1, '0);
                2: apply_setting($urandom_range(1, NUM_ROUTES), $urandom_range(1, NUM_IFACES),
                                 ADDR_W'($urandom));
                3: apply_setting(NUM_ROUTES, NUM_IFACES, {ADDR_W{1'b1}});
                4: apply_setting($urandom_range(0, (1 << ROUTE_COUNT_W) - 1),
                                 $urandom_range(0, (1 << IFACE_COUNT_W) - 1), '0);
                default: apply_setting(1, 1, '0);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    beat = next_random_item();
                    send_item(beat);
                    // Beats the block drops do not count toward the phase.
                    if (beat.action != ACT_UNUSED &&
                        !(beat.action == ACT_WR_IFACE && int'(beat.entry_index) >= NUM_IFACES))
                        sent++;
                end
                // A quarter of bursts run straight into the next one.
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 40));
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        route_limit = '0;
        iface_limit = '0;
        pref_src    = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_tables();
        load_tables();
        test_directed_lookups();
        test_register_extremes();
        test_random_traffic();
        drain_results();

        $display("Checked %0d lookups: %0d local, %0d routed, %0d with no route; %0d table writes",
                 lookups_checked, local_answers, routed_answers, unrouted_answers, table_writes);
        $display("Ran under %0d register settings with bursty commands and full drains",
                 settings_used);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d answers still owed", pending_decisions.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rtfm_pkg.sv
hw/rtl/rtfm_route_cell.sv
hw/rtl/rtfm_iface_cell.sv
hw/rtl/route_table_first_match_top.sv
hw/rtl/rtfm_checker.sv
bench/testbench.sv
